>>> rtl/core/pktb_pkg.sv
// package with shared types and constants for the pressed key table
`timescale 1ns / 1ps
`default_nettype none
package pktb_pkg;

  localparam int unsigned KeyW     = 8;
  localparam int unsigned OutSlots = 8;
  localparam int unsigned MTdataW  = 72;
  localparam int unsigned MPadW    = MTdataW - 1 - OutSlots * KeyW;

  localparam logic [KeyW-1:0] KeyEmpty = '0;

  typedef enum logic {
    MODE_DOWN = 1'b0,
    MODE_UP   = 1'b1
  } mode_e;

  typedef struct packed {
    logic                              stop;
    logic                              evt;
    logic [OutSlots-1:0][KeyW-1:0]     slots;
  } pktb_res_t;

endpackage
`default_nettype wire

>>> rtl/core/pktb_table.sv
// held key table with parallel slot compare and in-place update
`timescale 1ns / 1ps
`default_nettype none
module pktb_table import pktb_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            upd_i,
  input  wire mode_e           mode_i,
  input  wire logic [KeyW-1:0] code_i,
  input  wire logic [KeyW-1:0] blocked_key_i,
  output pktb_res_t            res_o
);

  logic [SLOTS-1:0][KeyW-1:0] held_q, held_d;
  logic [SLOTS-1:0]           hit;
  logic [SLOTS-1:0]           sel;
  logic [SLOTS-1:0]           blk_pre;
  logic                       code_nz;
  logic                       is_held;
  logic                       ins_any;
  logic                       found;
  logic                       blk_held;

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i]     = (held_q[i] == code_i);
      blk_pre[i] = (held_q[i] == blocked_key_i);
      sel[i]     = 1'b0;
      if (!found && held_q[i] == KeyEmpty) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  assign code_nz = (code_i != KeyEmpty);
  assign is_held = code_nz && (|hit);
  assign ins_any = code_nz && (mode_i == MODE_DOWN) && !is_held && found;
  assign blk_held = (blocked_key_i != KeyEmpty) &&
                    ((|blk_pre) || (ins_any && code_i == blocked_key_i));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      held_d[i] = held_q[i];
      if (code_nz) begin
        case (mode_i)
          MODE_DOWN: if (ins_any && sel[i]) held_d[i] = code_i;
          MODE_UP:   if (hit[i]) held_d[i] = KeyEmpty;
          default:   held_d[i] = held_q[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (upd_i) begin
      held_q <= held_d;
    end
  end

  always_comb begin
    res_o.evt  = code_nz && (mode_i == MODE_DOWN) && !is_held;
    res_o.stop = 1'b0;
    if (code_nz && mode_i == MODE_DOWN) begin
      res_o.stop = is_held ? (code_i == blocked_key_i) : blk_held;
    end
  end

  for (genvar k = 0; k < OutSlots; k++) begin : g_out
    if (k < SLOTS) begin : g_used
      assign res_o.slots[k] = res_o.evt ? held_d[k] : KeyEmpty;
    end else begin : g_unused
      assign res_o.slots[k] = KeyEmpty;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/pressed_key_table_with_block.sv
// top level of the pressed key table with one blocked key
// result path: an accepted item waits in the input register until the result register is free to take its result
// throughput: one item per cycle while the master side accepts results, table compare and update in a single pass
// input register and result register, ready passes back combinationally from the master side
// reset: asynchronous active low, clears the table, blocked key and valid flags
`timescale 1ns / 1ps
`default_nettype none
module pressed_key_table_with_block import pktb_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [KeyW-1:0]    cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [KeyW-1:0]    s_axis_tdata,  // pressed or released key
  input  wire logic               s_axis_tuser,  // mode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [MTdataW-1:0]      m_axis_tdata,  // stop_propagation, slot_0 .. slot_7, pad
  output logic                    m_axis_tuser   // event_valid
);

  logic [KeyW-1:0] blocked_q;
  logic            in_vld_q;
  mode_e           mode_q;
  logic [KeyW-1:0] code_q;
  logic            out_vld_q;
  pktb_res_t       res_q;
  pktb_res_t       res;
  logic            out_free;
  logic            adv;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= KeyEmpty;
    end else if (cfg_we_i) begin
      blocked_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= mode_e'(s_axis_tuser);
      code_q <= s_axis_tdata;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  pktb_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (adv),
    .mode_i       (mode_q),
    .code_i       (code_q),
    .blocked_key_i(blocked_q),
    .res_o        (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{MPadW{1'b0}}, res_q.slots, res_q.stop};
  assign m_axis_tuser  = res_q.evt;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q)
    else $error("input stalled with empty input register");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("advanced item did not reach result register");

  a_no_event_no_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (res_q.slots == '0))
    else $error("slots reported without table event");

  a_event_no_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(code_q)))
    else $error("pending item lost while result stalled");

endmodule
`default_nettype wire
